### design/pegt_pkg.sv
package pegt_pkg;

	localparam int ERR_W  = 16;
	localparam int GAIN_W = 32;
	localparam int RMS_W  = 32;
	localparam int LEN_W  = 16;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	// op codes
	localparam logic [1:0] OP_INIT   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_EPOCH  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;	// unused, reports state only

	// register indexes
	localparam logic [CFG_IW-1:0] REG_KP   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_KI   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_KD   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_LEN  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_THR  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_RATE = 3'd5;

endpackage

### design/pegt_ifs.sv
interface pegt_in_if;
	import pegt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               op;
	logic signed [ERR_W-1:0]  error_sample;
	modport source (output valid, op, error_sample, input ready);
	modport sink (input valid, op, error_sample, output ready);
endinterface

interface pegt_out_if;
	import pegt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [GAIN_W-1:0] control;
	logic [RMS_W-1:0]         epoch_rms;
	logic                     training_active;
	logic signed [GAIN_W-1:0] gain_p;
	logic signed [GAIN_W-1:0] gain_i;
	logic signed [GAIN_W-1:0] gain_d;
	modport source (output valid, control, epoch_rms, training_active, gain_p, gain_i,
		gain_d, input ready);
	modport sink (input valid, control, epoch_rms, training_active, gain_p, gain_i,
		gain_d, output ready);
endinterface

interface pegt_cfg_if;
	import pegt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/pid_controller_epoch_gain_tuning_core.sv
// channel | dir | payload                                          | accepted when
// req     | in  | op, error_sample                                 | valid && ready
// rsp     | out | control, epoch_rms, training_active, gain_p/i/d  | valid && ready
// cfg     | in  | index, data                                      | valid (ready tied high)
//
// An epoch end runs 48 restoring divide steps and 32 square root steps, and while tuning
// runs also 10 multiplier steps per gain; all ops share the one 32x32 multiplier, and
// the divide and root loops work one bit at a time.
// req.ready is high only while the sequencer idles; a finished word sits in the
// output register, so the next word may be taken while rsp stalls; that one then
// waits in the last sequencer state until the output register frees up.
// arst_n clears gains, error terms, sums and the sequencer; tuning flag resets high.
module pid_controller_epoch_gain_tuning_core (
	input logic clk,
	input logic arst_n,
	pegt_in_if.sink req,
	pegt_out_if.source rsp,
	pegt_cfg_if.sink cfg
);
	import pegt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SAMP = 8'b0000_0010,
		S_DIV  = 8'b0000_0100,
		S_SQRT = 8'b0000_1000,
		S_RMS  = 8'b0001_0000,
		S_TUNE = 8'b0010_0000,
		S_CTRL = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	localparam logic [39:0]  INT_HI = {1'b0, {39{1'b1}}};
	localparam logic [39:0]  INT_LO = {1'b1, 39'b0};
	localparam logic [79:0]  ADJ_LIM = {46'b0, 1'b1, 33'b0};
	localparam logic [103:0] TI_LIM = {53'b0, 1'b1, 50'b0};

	state_t state_q;
	logic [3:0] st_q;
	logic [1:0] g_q;
	logic [5:0] cnt_q;

	// config
	logic [31:0] ikp_q, iki_q, ikd_q, thr_q, rate_q;
	logic [15:0] elen_q;

	// controller state
	logic [15:0] le_q;
	logic [39:0] int_q;
	logic [16:0] ed_q;
	logic [39:0] abs_q;
	logic [47:0] sqs_q;
	logic [31:0] prev_q, cur_q;
	logic        ton_q;
	logic [31:0] kp_q, ki_q, kd_q;

	// datapath
	logic [15:0]  e_q;
	logic [63:0]  prod_q;
	logic [103:0] acc_q;
	logic [63:0]  m_q;
	logic [52:0]  tot_q;
	logic [31:0]  dmag_q;
	logic         dneg_q;
	logic [47:0]  dq_q;
	logic [15:0]  rem_q;
	logic [63:0]  sx_q, sr_q, sb_q;

	// output register
	logic        ovalid_q;
	logic [31:0] octl_q, orms_q, okp_q, oki_q, okd_q;
	logic        oton_q;

	logic [31:0] mul_a, mul_b;
	logic [15:0] le_mag, e_mag;
	logic [16:0] ed_mag;
	logic [39:0] int_mag;
	logic [31:0] kp_mag, ki_mag, kd_mag;
	logic [31:0] k_sel, k_mag;
	logic [39:0] at_sel;
	logic        t_neg;
	logic [16:0] div_rs, div_dv;
	logic        div_ge;
	logic [63:0] sq_t;
	logic        sq_ge;
	logic [79:0] adj_sh;
	logic [33:0] adj;
	logic [35:0] gsum;
	logic [31:0] gnew;
	logic [50:0] ti_m;
	logic [44:0] q45;
	logic [31:0] ctl;
	logic [40:0] int_s, abs_s;
	logic [48:0] sq_s;
	logic [32:0] dlt;
	logic        out_free;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = ovalid_q;
	assign rsp.control = octl_q;
	assign rsp.epoch_rms = orms_q;
	assign rsp.training_active = oton_q;
	assign rsp.gain_p = okp_q;
	assign rsp.gain_i = oki_q;
	assign rsp.gain_d = okd_q;

	assign out_free = !ovalid_q || rsp.ready;

	always_comb begin
		le_mag  = le_q[15] ? 16'(~le_q + 16'd1) : le_q;
		e_mag   = e_q[15] ? 16'(~e_q + 16'd1) : e_q;
		ed_mag  = ed_q[16] ? 17'(~ed_q + 17'd1) : ed_q;
		int_mag = int_q[39] ? 40'(~int_q + 40'd1) : int_q;
		kp_mag  = kp_q[31] ? 32'(~kp_q + 32'd1) : kp_q;
		ki_mag  = ki_q[31] ? 32'(~ki_q + 32'd1) : ki_q;
		kd_mag  = kd_q[31] ? 32'(~kd_q + 32'd1) : kd_q;

		// gain under tuning and its error term
		case (g_q)
			2'd0: begin
				k_sel  = kp_q;
				at_sel = {24'b0, le_mag};
				t_neg  = le_q[15];
			end
			2'd1: begin
				k_sel  = ki_q;
				at_sel = abs_q;
				t_neg  = 1'b0;
			end
			default: begin
				k_sel  = kd_q;
				at_sel = {23'b0, ed_mag};
				t_neg  = ed_q[16];
			end
		endcase
		k_mag = k_sel[31] ? 32'(~k_sel + 32'd1) : k_sel;

		// shared multiplier operands
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SAMP: begin
				mul_a = {16'b0, e_mag};
				mul_b = {16'b0, e_mag};
			end
			S_TUNE: begin
				case (st_q)
					4'd0: begin mul_a = k_mag;          mul_b = dmag_q; end
					4'd1: begin mul_a = prod_q[31:0];   mul_b = rate_q; end
					4'd2: begin mul_a = m_q[63:32];     mul_b = rate_q; end
					4'd4: begin mul_a = acc_q[31:0];    mul_b = at_sel[31:0]; end
					4'd5: begin mul_a = m_q[31:0];      mul_b = {24'b0, at_sel[39:32]}; end
					4'd6: begin mul_a = m_q[63:32];     mul_b = at_sel[31:0]; end
					4'd7: begin mul_a = m_q[63:32];     mul_b = {24'b0, at_sel[39:32]}; end
					default: ;
				endcase
			end
			S_CTRL: begin
				case (st_q)
					4'd0: begin mul_a = kp_mag; mul_b = {16'b0, le_mag}; end
					4'd1: begin mul_a = kd_mag; mul_b = {15'b0, ed_mag}; end
					4'd2: begin mul_a = ki_mag; mul_b = int_mag[31:0]; end
					4'd3: begin mul_a = ki_mag; mul_b = {24'b0, int_mag[39:32]}; end
					default: ;
				endcase
			end
			default: ;
		endcase

		// restoring divide step
		div_dv = {1'b0, (elen_q == 16'd0) ? 16'd1 : elen_q};
		div_rs = {rem_q, dq_q[47]};
		div_ge = (div_rs >= div_dv);

		// square root step
		sq_t  = sr_q + sb_q;
		sq_ge = (sx_q >= sq_t);

		// gain adjustment, clamped at 2^33
		adj_sh = acc_q[103:24];
		adj    = (adj_sh > ADJ_LIM) ? ADJ_LIM[33:0] : adj_sh[33:0];
		gsum   = (k_sel[31] ^ dneg_q ^ t_neg) ? ({{4{k_sel[31]}}, k_sel} - {2'b0, adj})
			: ({{4{k_sel[31]}}, k_sel} + {2'b0, adj});
		if ((&gsum[35:31]) || !(|gsum[35:31]))
			gnew = gsum[31:0];
		else
			gnew = gsum[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;

		// integral term magnitude clamp
		ti_m = (acc_q > TI_LIM) ? TI_LIM[50:0] : acc_q[50:0];

		// floor shift and saturate the control sum
		q45 = tot_q[52:8];
		if ((&q45[44:31]) || !(|q45[44:31]))
			ctl = q45[31:0];
		else
			ctl = q45[44] ? 32'h8000_0000 : 32'h7FFF_FFFF;

		// sample sums
		int_s = {int_q[39], int_q} + {{25{e_q[15]}}, e_q};
		abs_s = {1'b0, abs_q} + {25'b0, e_mag};
		sq_s  = {1'b0, sqs_q} + {1'b0, prod_q[47:0]};

		dlt = {1'b0, prev_q} - {1'b0, sr_q[31:0]};
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			st_q     <= '0;
			g_q      <= '0;
			cnt_q    <= '0;
			ikp_q    <= '0;
			iki_q    <= '0;
			ikd_q    <= '0;
			elen_q   <= 16'd1;
			thr_q    <= '0;
			rate_q   <= '0;
			le_q     <= '0;
			int_q    <= '0;
			ed_q     <= '0;
			abs_q    <= '0;
			sqs_q    <= '0;
			prev_q   <= '0;
			cur_q    <= '0;
			ton_q    <= 1'b1;
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_KP:   ikp_q <= cfg.data;
					REG_KI:   iki_q <= cfg.data;
					REG_KD:   ikd_q <= cfg.data;
					REG_LEN:  elen_q <= cfg.data[15:0];
					REG_THR:  thr_q <= cfg.data;
					REG_RATE: rate_q <= cfg.data;
					default: ;
				endcase
			end

			// a new word loads as the old one leaves
			if (state_q == S_DONE && out_free)
				ovalid_q <= 1'b1;
			else if (ovalid_q && rsp.ready)
				ovalid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					st_q <= '0;
					g_q  <= '0;
					if (req.valid) begin
						case (req.op)
							OP_INIT: begin
								kp_q    <= ikp_q;
								ki_q    <= iki_q;
								kd_q    <= ikd_q;
								le_q    <= '0;
								int_q   <= '0;
								ed_q    <= '0;
								abs_q   <= '0;
								sqs_q   <= '0;
								prev_q  <= '0;
								cur_q   <= '0;
								ton_q   <= 1'b1;
								state_q <= S_CTRL;
							end
							OP_SAMPLE: state_q <= S_SAMP;
							OP_EPOCH: begin
								cnt_q   <= 6'd47;
								state_q <= S_DIV;
							end
							default: state_q <= S_CTRL;
						endcase
					end
				end
				S_SAMP: begin
					if (st_q == 4'd0) begin
						st_q <= 4'd1;
					end else begin
						ed_q <= 17'({e_q[15], e_q} - {le_q[15], le_q});
						le_q <= e_q;
						if (int_s[40] != int_s[39])
							int_q <= int_s[40] ? INT_LO : INT_HI;
						else
							int_q <= int_s[39:0];
						abs_q   <= abs_s[40] ? {40{1'b1}} : abs_s[39:0];
						sqs_q   <= sq_s[48] ? {48{1'b1}} : sq_s[47:0];
						st_q    <= '0;
						state_q <= S_CTRL;
					end
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						cnt_q   <= 6'd31;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_SQRT: begin
					if (cnt_q == 6'd0)
						state_q <= S_RMS;
					else
						cnt_q <= cnt_q - 6'd1;
				end
				S_RMS: begin
					cur_q <= sr_q[31:0];
					st_q  <= '0;
					g_q   <= '0;
					if (ton_q) begin
						ton_q   <= (sr_q[31:0] > thr_q);
						prev_q  <= sr_q[31:0];
						state_q <= S_TUNE;
					end else begin
						abs_q   <= '0;
						sqs_q   <= '0;
						state_q <= S_CTRL;
					end
				end
				S_TUNE: begin
					if (st_q == 4'd9) begin
						case (g_q)
							2'd0:    kp_q <= gnew;
							2'd1:    ki_q <= gnew;
							default: kd_q <= gnew;
						endcase
						st_q <= '0;
						if (g_q == 2'd2) begin
							abs_q   <= '0;
							sqs_q   <= '0;
							state_q <= S_CTRL;
						end else begin
							g_q <= g_q + 2'd1;
						end
					end else begin
						st_q <= st_q + 4'd1;
					end
				end
				S_CTRL: begin
					if (st_q == 4'd5)
						state_q <= S_DONE;
					else
						st_q <= st_q + 4'd1;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath and output payload
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (state_q == S_IDLE && req.valid) begin
			e_q   <= req.error_sample;
			dq_q  <= sqs_q;
			rem_q <= '0;
		end

		if (state_q == S_DIV) begin
			rem_q <= div_ge ? 16'(div_rs - div_dv) : div_rs[15:0];
			dq_q  <= {dq_q[46:0], div_ge};
			if (cnt_q == 6'd0) begin
				// last quotient bit lands with the root operand load
				sx_q <= {dq_q[46:0], div_ge, 16'b0};
				sr_q <= '0;
				sb_q <= {2'b01, 62'b0};
			end
		end

		if (state_q == S_SQRT) begin
			if (sq_ge) begin
				sx_q <= sx_q - sq_t;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end

		if (state_q == S_RMS) begin
			dneg_q <= dlt[32];
			dmag_q <= dlt[32] ? 32'(~dlt + 33'd1) : dlt[31:0];
		end

		if (state_q == S_TUNE) begin
			case (st_q)
				4'd1: m_q <= prod_q;
				4'd2: acc_q <= {72'b0, prod_q[63:32]};
				4'd3: acc_q <= acc_q + {40'b0, prod_q};
				4'd4: m_q <= acc_q[63:0];
				4'd5: acc_q <= {40'b0, prod_q};
				4'd6: acc_q <= acc_q + {8'b0, prod_q, 32'b0};
				4'd7: acc_q <= acc_q + {8'b0, prod_q, 32'b0};
				4'd8: acc_q <= acc_q + {prod_q[39:0], 64'b0};
				default: ;
			endcase
		end

		if (state_q == S_CTRL) begin
			case (st_q)
				4'd1: tot_q <= (kp_q[31] ^ le_q[15]) ? {5'b0, prod_q[47:0]}
					: 53'(-{5'b0, prod_q[47:0]});
				4'd2: tot_q <= (kd_q[31] ^ ed_q[16]) ? tot_q + {5'b0, prod_q[47:0]}
					: tot_q - {5'b0, prod_q[47:0]};
				4'd3: acc_q <= {40'b0, prod_q};
				4'd4: acc_q <= acc_q + {8'b0, prod_q, 32'b0};
				4'd5: tot_q <= (ki_q[31] ^ int_q[39]) ? tot_q + {2'b0, ti_m}
					: tot_q - {2'b0, ti_m};
				default: ;
			endcase
		end

		if (state_q == S_DONE && out_free) begin
			octl_q <= ctl;
			orms_q <= cur_q;
			oton_q <= ton_q;
			okp_q  <= kp_q;
			oki_q  <= ki_q;
			okd_q  <= kd_q;
		end
	end

endmodule

### design/pegt_chk.sv
module pegt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_control,
	input logic [31:0] rsp_epoch_rms,
	input logic        rsp_training_active,
	input logic [31:0] rsp_gain_p,
	input logic [31:0] rsp_gain_i,
	input logic [31:0] rsp_gain_d
);

	// a taken word leaves the sequencer busy, so ready drops after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req ready right after accept");

	// no result appears unless a word was taken earlier
	a_rsp_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result without work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_control) && $stable(rsp_epoch_rms)
			&& $stable(rsp_training_active) && $stable(rsp_gain_p)
			&& $stable(rsp_gain_i) && $stable(rsp_gain_d))
		else $error("rsp payload moved");

endmodule

bind pid_controller_epoch_gain_tuning_core pegt_chk u_pegt_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_control(rsp.control),
	.rsp_epoch_rms(rsp.epoch_rms),
	.rsp_training_active(rsp.training_active),
	.rsp_gain_p(rsp.gain_p),
	.rsp_gain_i(rsp.gain_i),
	.rsp_gain_d(rsp.gain_d)
);

### test/pid_controller_epoch_gain_tuning_core_tb.sv
module pid_controller_epoch_gain_tuning_core_tb;
	import pegt_pkg::*;

	// one output word as the block should report it
	typedef struct {
		logic signed [GAIN_W-1:0] control;
		logic [RMS_W-1:0]         epoch_rms;
		logic                     training_active;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
	} pid_word_t;

	localparam longint INTEG_HI = 64'sd549755813887;   // 40-bit signed limits
	localparam longint INTEG_LO = -64'sd549755813888;
	localparam longint unsigned ABS_SUM_MAX = 64'd1099511627775;
	localparam longint unsigned SQ_SUM_MAX  = 64'd281474976710655;
	localparam int SETTLE_CYCLES = 200;     // covers one epoch end and then some
	localparam int CYCLE_LIMIT   = 2000000;

	// Mirror of the controller: register copies, error terms, epoch sums, gains.
	// Every request produces exactly one word, so expectations sit in one FIFO.
	class gain_tuning_mirror;
		logic [31:0] init_kp, init_ki, init_kd, thresh, rate;
		logic [15:0] epoch_len;
		longint last_err, integ, delta_err, kp, ki, kd;
		longint unsigned abs_sum, sq_sum, prev_rms, cur_rms;
		bit tuning;
		pid_word_t pending_words[$];
		int mismatches;

		function new();
			init_kp = '0; init_ki = '0; init_kd = '0;
			thresh = '0; rate = '0; epoch_len = 16'd1;
			kp = 0; ki = 0; kd = 0;
			clear_run();
			mismatches = 0;
		endfunction

		function void clear_run();
			last_err = 0; integ = 0; delta_err = 0;
			abs_sum = 0; sq_sum = 0; prev_rms = 0; cur_rms = 0;
			tuning = 1'b1;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_KP: init_kp = val;
				REG_KI: init_ki = val;
				REG_KD: init_kd = val;
				REG_LEN: epoch_len = val[15:0];
				REG_THR: thresh = val;
				REG_RATE: rate = val;
				default: ;
			endcase
		endfunction

		static function longint unsigned magn(longint v);
			return (v < 0) ? longint'(-v) : v;
		endfunction

		static function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		static function longint unsigned floor_sqrt(longint unsigned x);
			logic [127:0] r, t;
			r = '0;
			for (int i = 31; i >= 0; i--) begin
				t = r | (128'd1 << i);
				if (t * t <= 128'(x)) r = t;
			end
			return r[63:0];
		endfunction

		// gain += sign * min(((|k|*|dRMS|*rate)>>32)*|term|>>24, 2^33)
		static function longint retune(longint k, longint d, longint unsigned lr, longint term);
			logic [127:0] prod;
			longint unsigned adj;
			bit neg;
			prod = 128'(magn(k)) * 128'(magn(d));
			prod = (prod * 128'(lr)) >> 32;
			prod = (prod * 128'(magn(term))) >> 24;
			adj = (prod > (128'd1 << 33)) ? (64'd1 << 33) : prod[63:0];
			neg = ((k < 0) != (d < 0)) != (term < 0);
			return sat32(neg ? k - longint'(adj) : k + longint'(adj));
		endfunction

		function longint drive_now();
			longint tp, td, ti, total;
			logic [127:0] m;
			tp = kp * last_err;
			td = kd * delta_err;
			m = 128'(magn(ki)) * 128'(magn(integ));
			if (m > (128'd1 << 50)) m = 128'd1 << 50;   // Ki term clamp
			ti = ((ki < 0) != (integ < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
			total = -(tp + ti + td);
			return sat32(total >>> 8);                   // floor divide by 2^8
		endfunction

		function void take_request(logic [1:0] op, logic signed [ERR_W-1:0] err);
			longint e, d;
			longint unsigned ae, sq, len, rms;
			pid_word_t w;
			case (op)
				OP_INIT: begin
					kp = longint'($signed(init_kp));
					ki = longint'($signed(init_ki));
					kd = longint'($signed(init_kd));
					clear_run();
				end
				OP_SAMPLE: begin
					e = longint'(err);
					ae = magn(e);
					sq = ae * ae;
					delta_err = e - last_err;
					last_err = e;
					integ = integ + e;
					if (integ > INTEG_HI) integ = INTEG_HI;
					if (integ < INTEG_LO) integ = INTEG_LO;
					abs_sum = (abs_sum > ABS_SUM_MAX - ae) ? ABS_SUM_MAX : abs_sum + ae;
					sq_sum = (sq_sum > SQ_SUM_MAX - sq) ? SQ_SUM_MAX : sq_sum + sq;
				end
				OP_EPOCH: begin
					len = (epoch_len == 16'd0) ? 1 : longint'(epoch_len);
					rms = floor_sqrt((sq_sum / len) << 16);
					cur_rms = rms;
					if (tuning) begin
						d = longint'(prev_rms) - longint'(rms);
						tuning = rms > longint'(thresh);
						prev_rms = rms;
						kp = retune(kp, d, rate, last_err);
						ki = retune(ki, d, rate, longint'(abs_sum));
						kd = retune(kd, d, rate, delta_err);
					end
					abs_sum = 0;
					sq_sum = 0;
				end
				default: ;   // unused op: state untouched
			endcase
			w.control = drive_now();
			w.epoch_rms = cur_rms[31:0];
			w.training_active = tuning;
			w.gain_p = kp[31:0];
			w.gain_i = ki[31:0];
			w.gain_d = kd[31:0];
			pending_words.push_back(w);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			mismatches++;
		endtask

		task match_word(pid_word_t got);
			pid_word_t want;
			if (pending_words.size() == 0) begin
				report("unexpected word", got.control, '0);
			end else begin
				want = pending_words.pop_front();
				if (got.control !== want.control) report("control", got.control, want.control);
				if (got.epoch_rms !== want.epoch_rms)
					report("epoch_rms", got.epoch_rms, want.epoch_rms);
				if (got.training_active !== want.training_active)
					report("training_active", 32'(got.training_active),
						32'(want.training_active));
				if (got.gain_p !== want.gain_p) report("gain_p", got.gain_p, want.gain_p);
				if (got.gain_i !== want.gain_i) report("gain_i", got.gain_i, want.gain_i);
				if (got.gain_d !== want.gain_d) report("gain_d", got.gain_d, want.gain_d);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	pegt_in_if  req_bus();
	pegt_out_if rsp_bus();
	pegt_cfg_if cfg_bus();

	pid_controller_epoch_gain_tuning_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus.sink),
		.rsp(rsp_bus.source),
		.cfg(cfg_bus.sink)
	);

	gain_tuning_mirror mirror = new();
	int  words_sent;
	int  words_seen;
	bit  send_calm;     // sender offers back to back
	bit  recv_calm;     // receiver does not stall, apart from the one long hold-off
	bit  pressure_done;
	int  cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Send one request; valid stays high across back-to-back words.
	task send_word(logic [1:0] op, logic signed [ERR_W-1:0] err);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.op <= op;
		req_bus.error_sample <= err;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		mirror.take_request(op, err);
		words_sent++;
	endtask

	// Stop offering and let the block drain before touching registers.
	task drain();
		req_bus.valid <= 1'b0;
		while (mirror.pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_regs(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
		logic [15:0] len, logic [31:0] thr, logic [31:0] lr);
		logic [31:0] vals[6];
		logic [CFG_IW-1:0] idx[6];
		vals = '{kp, ki, kd, 32'(len), thr, lr};
		idx = '{REG_KP, REG_KI, REG_KD, REG_LEN, REG_THR, REG_RATE};
		for (int i = 0; i < 6; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[i];
			cfg_bus.data <= vals[i];
			@(posedge clk);
			while (!cfg_bus.ready) @(posedge clk);
			mirror.set_reg(idx[i], vals[i]);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic signed [ERR_W-1:0] pick_error();
		case ($urandom_range(0, 5))
			0: return 16'(32'($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000);
			1, 2: return ERR_W'($signed(32'($urandom_range(0, 2047)) - 1024));
			3: return ERR_W'($signed(32'($urandom_range(0, 255)) - 128));
			default: return ERR_W'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			1, 2: return 32'($signed(32'($urandom_range(0, 8 << 16)) - (4 << 16)));
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, calm stretches, and one long hold-off that backs
	// the block up until it stops taking requests.
	initial begin
		int gap;
		pid_word_t got;
		rsp_bus.ready <= 1'b0;
		pressure_done = 1'b0;
		recv_calm = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (words_seen % 150 == 0) recv_calm = ($urandom_range(0, 3) == 0);
			gap = recv_calm ? 0 : $urandom_range(0, 18);
			if (!pressure_done && words_seen == 300) begin
				gap = 600;
				pressure_done = 1'b1;
			end
			if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_bus.valid) @(posedge clk);
			got.control = rsp_bus.control;
			got.epoch_rms = rsp_bus.epoch_rms;
			got.training_active = rsp_bus.training_active;
			got.gain_p = rsp_bus.gain_p;
			got.gain_i = rsp_bus.gain_i;
			got.gain_d = rsp_bus.gain_d;
			mirror.match_word(got);
			words_seen++;
		end
	end

	// Stimulus
	initial begin
		int n;
		logic [15:0] len;
		logic [31:0] thr;
		arst_n = 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.op <= OP_INIT;
		req_bus.error_sample <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_KP;
		cfg_bus.data <= '0;
		words_sent = 0;
		words_seen = 0;
		send_calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, then field extremes and every op
		send_word(OP_SAMPLE, 16'sh7fff);
		send_word(OP_SAMPLE, 16'sh8000);
		send_word(OP_NONE, 16'sh1234);         // unused op reports state only
		send_word(OP_EPOCH, '0);
		drain();
		// saturating gains, full rate, threshold zero keeps tuning on while the RMS is above zero
		write_regs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd1, 32'h0, 32'hffffffff);
		send_word(OP_INIT, '0);
		send_word(OP_SAMPLE, 16'sh8000);
		send_word(OP_SAMPLE, 16'sh7fff);
		send_word(OP_SAMPLE, 16'sh0000);
		send_word(OP_SAMPLE, 16'shffff);
		send_word(OP_EPOCH, '0);
		send_word(OP_SAMPLE, 16'sh0001);
		send_word(OP_EPOCH, '0);
		send_word(OP_EPOCH, '0);               // empty epoch
		drain();
		// epoch length zero acts as one; top threshold stops tuning at once
		write_regs(32'h80000000, 32'h7fffffff, 32'h80000000, 16'd0, 32'hffffffff, 32'h0);
		send_word(OP_INIT, '0);
		send_word(OP_SAMPLE, 16'sh4000);
		send_word(OP_EPOCH, '0);
		send_word(OP_SAMPLE, 16'shc000);
		send_word(OP_EPOCH, '0);
		drain();
		write_regs(32'h00010000, 32'hffff0000, 32'h00008000, 16'hffff, 32'h00000100,
			32'h80000000);
		send_word(OP_INIT, '0);
		send_word(OP_SAMPLE, 16'sh7fff);
		send_word(OP_SAMPLE, 16'sh8000);
		send_word(OP_EPOCH, '0);
		drain();

		// random phases: fresh registers, init, then whole epochs with noise
		while (words_sent < 1700) begin
			send_calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: len = 16'hffff;
				1: len = 16'd0;
				default: len = 16'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 4))
				0: thr = 32'h0;
				1: thr = $urandom;
				default: thr = $urandom_range(0, 1 << 24);
			endcase
			write_regs(pick_gain(), pick_gain(), pick_gain(), len, thr,
				$urandom_range(0, 3) == 0 ? 32'hffffffff : $urandom);
			send_word(OP_INIT, '0);
			repeat ($urandom_range(3, 10)) begin
				n = $urandom_range(1, (len == 0 || len > 12) ? 14 : int'(len) + 2);
				repeat (n) begin
					case ($urandom_range(0, 39))
						0: send_word(OP_NONE, ERR_W'($urandom));
						1: send_word(OP_INIT, ERR_W'($urandom));
						default: send_word(OP_SAMPLE, pick_error());
					endcase
				end
				send_word(OP_EPOCH, ERR_W'($urandom));
			end
			drain();
		end

		if (mirror.mismatches == 0 && mirror.pending_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### pid_controller_epoch_gain_tuning_core.f
design/pegt_pkg.sv
design/pegt_ifs.sv
design/pid_controller_epoch_gain_tuning_core.sv
design/pegt_chk.sv
test/pid_controller_epoch_gain_tuning_core_tb.sv
